>>> rtl/idec_pkg.sv
// ----------------------------------------------------------------------------
// idec_pkg
// Shared types and codes for the RV32I instruction decoder: opcodes, format
// codes, operation numbers and the decoded result record.
// ----------------------------------------------------------------------------
`default_nettype none

package idec_pkg;

  // major opcodes, instruction bits 6:0
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct12 values for system instructions
  localparam logic [11:0] F12_ECALL  = 12'h000;
  localparam logic [11:0] F12_EBREAK = 12'h001;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

  // instruction formats
  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_U = 3'd4;
  localparam logic [2:0] FMT_J = 3'd5;

  // operation numbers
  localparam logic [5:0] OP_ADD    = 6'd0;
  localparam logic [5:0] OP_SUB    = 6'd1;
  localparam logic [5:0] OP_SLL    = 6'd2;
  localparam logic [5:0] OP_SLT    = 6'd3;
  localparam logic [5:0] OP_SLTU   = 6'd4;
  localparam logic [5:0] OP_XOR    = 6'd5;
  localparam logic [5:0] OP_SRL    = 6'd6;
  localparam logic [5:0] OP_SRA    = 6'd7;
  localparam logic [5:0] OP_OR     = 6'd8;
  localparam logic [5:0] OP_AND    = 6'd9;
  localparam logic [5:0] OP_BEQ    = 6'd10;
  localparam logic [5:0] OP_BNE    = 6'd11;
  localparam logic [5:0] OP_BLT    = 6'd12;
  localparam logic [5:0] OP_BGE    = 6'd13;
  localparam logic [5:0] OP_BLTU   = 6'd14;
  localparam logic [5:0] OP_BGEU   = 6'd15;
  localparam logic [5:0] OP_LB     = 6'd16;
  localparam logic [5:0] OP_LH     = 6'd17;
  localparam logic [5:0] OP_LW     = 6'd18;
  localparam logic [5:0] OP_LBU    = 6'd19;
  localparam logic [5:0] OP_LHU    = 6'd20;
  localparam logic [5:0] OP_SB     = 6'd21;
  localparam logic [5:0] OP_SH     = 6'd22;
  localparam logic [5:0] OP_SW     = 6'd23;
  localparam logic [5:0] OP_ADDI   = 6'd24;
  localparam logic [5:0] OP_SLTI   = 6'd25;
  localparam logic [5:0] OP_SLTIU  = 6'd26;
  localparam logic [5:0] OP_XORI   = 6'd27;
  localparam logic [5:0] OP_ORI    = 6'd28;
  localparam logic [5:0] OP_ANDI   = 6'd29;
  localparam logic [5:0] OP_SLLI   = 6'd30;
  localparam logic [5:0] OP_SRLI   = 6'd31;
  localparam logic [5:0] OP_SRAI   = 6'd32;
  localparam logic [5:0] OP_JALR   = 6'd33;
  localparam logic [5:0] OP_ECALL  = 6'd34;
  localparam logic [5:0] OP_EBREAK = 6'd35;
  localparam logic [5:0] OP_FENCE  = 6'd36;
  localparam logic [5:0] OP_LUI    = 6'd37;
  localparam logic [5:0] OP_AUIPC  = 6'd38;
  localparam logic [5:0] OP_JAL    = 6'd39;

  typedef struct packed {
    logic               illegal;
    logic [2:0]         format;
    logic [5:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
  } dec_result_t;

endpackage

`default_nettype wire

>>> rtl/idec_decode.sv
// ----------------------------------------------------------------------------
// idec_decode
// Combinational decode of one RV32I instruction word into format, operation,
// register indices and immediate; illegal words give a record zeroed but for the flag.
// ----------------------------------------------------------------------------
`default_nettype none

module idec_decode (
  input  wire logic [31:0]          instruction,
  output idec_pkg::dec_result_t     result
);

  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [11:0] f12;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;

  logic        ok;
  logic [2:0]  fmt;
  logic [5:0]  op;
  logic [4:0]  d;
  logic [4:0]  s1;
  logic [4:0]  s2;
  logic [31:0] imm;

  assign opcode = instruction[6:0];
  assign f3     = instruction[14:12];
  assign f7     = instruction[31:25];
  assign rd     = instruction[11:7];
  assign rs1    = instruction[19:15];
  assign rs2    = instruction[24:20];
  assign f12    = instruction[31:20];

  assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
  assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign imm_b = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                  instruction[11:8], 1'b0};
  assign imm_j = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                  instruction[30:21], 1'b0};

  always_comb begin
    ok  = 1'b1;
    fmt = idec_pkg::FMT_R;
    op  = idec_pkg::OP_ADD;
    d   = '0;
    s1  = '0;
    s2  = '0;
    imm = '0;
    case (opcode)
      idec_pkg::OPC_OP: begin
        fmt = idec_pkg::FMT_R;
        d   = rd;
        s1  = rs1;
        s2  = rs2;
        case (f3)
          3'd0: begin
            if (f7 == idec_pkg::F7_BASE) op = idec_pkg::OP_ADD;
            else if (f7 == idec_pkg::F7_ALT) op = idec_pkg::OP_SUB;
            else ok = 1'b0;
          end
          3'd1: op = idec_pkg::OP_SLL;
          3'd2: op = idec_pkg::OP_SLT;
          3'd3: op = idec_pkg::OP_SLTU;
          3'd4: op = idec_pkg::OP_XOR;
          3'd5: begin
            if (f7 == idec_pkg::F7_BASE) op = idec_pkg::OP_SRL;
            else if (f7 == idec_pkg::F7_ALT) op = idec_pkg::OP_SRA;
            else ok = 1'b0;
          end
          3'd6: op = idec_pkg::OP_OR;
          default: op = idec_pkg::OP_AND;
        endcase
      end
      idec_pkg::OPC_LOAD: begin
        fmt = idec_pkg::FMT_I;
        d   = rd;
        s1  = rs1;
        imm = imm_i;
        case (f3)
          3'd0: op = idec_pkg::OP_LB;
          3'd1: op = idec_pkg::OP_LH;
          3'd2: op = idec_pkg::OP_LW;
          3'd4: op = idec_pkg::OP_LBU;
          3'd5: op = idec_pkg::OP_LHU;
          default: ok = 1'b0;
        endcase
      end
      idec_pkg::OPC_OP_IMM: begin
        fmt = idec_pkg::FMT_I;
        d   = rd;
        s1  = rs1;
        imm = imm_i;
        case (f3)
          3'd0: op = idec_pkg::OP_ADDI;
          3'd1: begin
            op  = idec_pkg::OP_SLLI;
            imm = {27'd0, rs2};
          end
          3'd2: op = idec_pkg::OP_SLTI;
          3'd3: op = idec_pkg::OP_SLTIU;
          3'd4: op = idec_pkg::OP_XORI;
          3'd5: begin
            imm = {27'd0, rs2};
            if (f7 == idec_pkg::F7_BASE) op = idec_pkg::OP_SRLI;
            else if (f7 == idec_pkg::F7_ALT) op = idec_pkg::OP_SRAI;
            else ok = 1'b0;
          end
          3'd6: op = idec_pkg::OP_ORI;
          default: op = idec_pkg::OP_ANDI;
        endcase
      end
      idec_pkg::OPC_JALR: begin
        fmt = idec_pkg::FMT_I;
        op  = idec_pkg::OP_JALR;
        d   = rd;
        s1  = rs1;
        imm = imm_i;
      end
      idec_pkg::OPC_SYSTEM: begin
        fmt = idec_pkg::FMT_I;
        if (f3 != 3'd0) ok = 1'b0;
        else if (f12 == idec_pkg::F12_ECALL) op = idec_pkg::OP_ECALL;
        else if (f12 == idec_pkg::F12_EBREAK) op = idec_pkg::OP_EBREAK;
        else ok = 1'b0;
      end
      idec_pkg::OPC_FENCE: begin
        fmt = idec_pkg::FMT_I;
        op  = idec_pkg::OP_FENCE;
      end
      idec_pkg::OPC_STORE: begin
        fmt = idec_pkg::FMT_S;
        s1  = rs1;
        s2  = rs2;
        imm = imm_s;
        case (f3)
          3'd0: op = idec_pkg::OP_SB;
          3'd1: op = idec_pkg::OP_SH;
          3'd2: op = idec_pkg::OP_SW;
          default: ok = 1'b0;
        endcase
      end
      idec_pkg::OPC_BRANCH: begin
        fmt = idec_pkg::FMT_B;
        s1  = rs1;
        s2  = rs2;
        imm = imm_b;
        case (f3)
          3'd0: op = idec_pkg::OP_BEQ;
          3'd1: op = idec_pkg::OP_BNE;
          3'd4: op = idec_pkg::OP_BLT;
          3'd5: op = idec_pkg::OP_BGE;
          3'd6: op = idec_pkg::OP_BLTU;
          3'd7: op = idec_pkg::OP_BGEU;
          default: ok = 1'b0;
        endcase
      end
      idec_pkg::OPC_LUI: begin
        fmt = idec_pkg::FMT_U;
        op  = idec_pkg::OP_LUI;
        d   = rd;
        imm = instruction & idec_pkg::UPPER_MASK;
      end
      idec_pkg::OPC_AUIPC: begin
        fmt = idec_pkg::FMT_U;
        op  = idec_pkg::OP_AUIPC;
        d   = rd;
        imm = instruction & idec_pkg::UPPER_MASK;
      end
      idec_pkg::OPC_JAL: begin
        fmt = idec_pkg::FMT_J;
        op  = idec_pkg::OP_JAL;
        d   = rd;
        imm = imm_j;
      end
      default: ok = 1'b0;
    endcase
  end

  // illegal words carry nothing but the flag
  always_comb begin
    if (ok) begin
      result.illegal   = 1'b0;
      result.format    = fmt;
      result.operation = op;
      result.dest_reg  = d;
      result.src1_reg  = s1;
      result.src2_reg  = s2;
      result.immediate = imm;
    end else begin
      result           = '0;
      result.illegal   = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rv32i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Pipelined RV32I instruction decoder: input register, decode logic and
// result register, one item per cycle while out_ready stays high.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_ready  instruction word
//  out_      output     out_valid/out_ready  illegal, format, operation,
//                                            register indices, immediate
//
//  out_valid rises once an accepted word has passed the input register, the
//  decode logic and the result register; one item per cycle sustained while
//  out_ready is high, set by the single decode stage between the two registers
//  stalls on out_ready propagate back through in_ready the same cycle,
//  with each stage advancing whenever the stage after it can take an item
//  synchronous active-low reset clears both stage valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_instruction_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [31:0]        in_instruction,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               out_illegal,
  output      logic [2:0]         out_format,
  output      logic [5:0]         out_operation,
  output      logic [4:0]         out_dest_reg,
  output      logic [4:0]         out_src1_reg,
  output      logic [4:0]         out_src2_reg,
  output      logic signed [31:0] out_immediate
);

  logic                  in_valid_r;
  logic [31:0]           instr_r;
  logic                  res_valid_r;
  idec_pkg::dec_result_t res_r;
  idec_pkg::dec_result_t res_nxt;
  logic                  res_take;

  idec_decode u_decode (
    .instruction (instr_r),
    .result      (res_nxt)
  );

  assign res_take = !res_valid_r || out_ready;
  assign in_ready = !in_valid_r || res_take;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      instr_r <= in_instruction;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_take) begin
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_illegal   = res_r.illegal;
  assign out_format    = res_r.format;
  assign out_operation = res_r.operation;
  assign out_dest_reg  = res_r.dest_reg;
  assign out_src1_reg  = res_r.src1_reg;
  assign out_src2_reg  = res_r.src2_reg;
  assign out_immediate = res_r.immediate;

endmodule

`default_nettype wire

>>> sim/tb_rv32i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_decoder
// Self-checking bench for the RV32I decoder. Each accepted instruction word
// is decoded by a behavioral model inside a small scoreboard. Every result
// item that leaves the block is matched in order against that model. Traffic
// runs in three phases: two throttled, one at full rate with a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rv32i_instruction_decoder;
  import idec_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 64;
  localparam int REPORT_LIMIT = 10;

  class decode_board;
    dec_result_t pending_decodes[$];
    int          errors;
    int          mismatches;
    int          checked;
    int          illegal_seen;
    bit          op_seen[64];

    function dec_result_t decode_word(logic [31:0] w);
      dec_result_t r;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm_i;
      bit          ok;
      f3    = w[14:12];
      f7    = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      ok    = 1'b1;
      r     = '0;
      case (w[6:0])
        OPC_OP: begin
          r.format = FMT_R;
          r.dest_reg = w[11:7];
          r.src1_reg = w[19:15];
          r.src2_reg = w[24:20];
          case (f3)
            3'd0: r.operation = (f7 == F7_ALT) ? OP_SUB : OP_ADD;
            3'd1: r.operation = OP_SLL;
            3'd2: r.operation = OP_SLT;
            3'd3: r.operation = OP_SLTU;
            3'd4: r.operation = OP_XOR;
            3'd5: r.operation = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
            3'd6: r.operation = OP_OR;
            default: r.operation = OP_AND;
          endcase
          if ((f3 == 3'd0 || f3 == 3'd5) && f7 != F7_BASE && f7 != F7_ALT) ok = 1'b0;
        end
        OPC_LOAD: begin
          r.format = FMT_I;
          r.dest_reg = w[11:7];
          r.src1_reg = w[19:15];
          r.immediate = imm_i;
          case (f3)
            3'd0: r.operation = OP_LB;
            3'd1: r.operation = OP_LH;
            3'd2: r.operation = OP_LW;
            3'd4: r.operation = OP_LBU;
            3'd5: r.operation = OP_LHU;
            default: ok = 1'b0;
          endcase
        end
        OPC_OP_IMM: begin
          r.format = FMT_I;
          r.dest_reg = w[11:7];
          r.src1_reg = w[19:15];
          // shifts carry an unsigned shamt
          r.immediate = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, w[24:20]} : imm_i;
          case (f3)
            3'd0: r.operation = OP_ADDI;
            3'd1: r.operation = OP_SLLI;
            3'd2: r.operation = OP_SLTI;
            3'd3: r.operation = OP_SLTIU;
            3'd4: r.operation = OP_XORI;
            3'd5: begin
              r.operation = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
              if (f7 != F7_BASE && f7 != F7_ALT) ok = 1'b0;
            end
            3'd6: r.operation = OP_ORI;
            default: r.operation = OP_ANDI;
          endcase
        end
        OPC_JALR: begin
          r.format = FMT_I;
          r.operation = OP_JALR;
          r.dest_reg = w[11:7];
          r.src1_reg = w[19:15];
          r.immediate = imm_i;
        end
        OPC_SYSTEM: begin
          r.format = FMT_I;
          if (f3 != 3'd0) ok = 1'b0;
          else if (w[31:20] == F12_ECALL) r.operation = OP_ECALL;
          else if (w[31:20] == F12_EBREAK) r.operation = OP_EBREAK;
          else ok = 1'b0;
        end
        OPC_FENCE: begin
          r.format = FMT_I;
          r.operation = OP_FENCE;
        end
        OPC_STORE: begin
          r.format = FMT_S;
          r.src1_reg = w[19:15];
          r.src2_reg = w[24:20];
          r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
          case (f3)
            3'd0: r.operation = OP_SB;
            3'd1: r.operation = OP_SH;
            3'd2: r.operation = OP_SW;
            default: ok = 1'b0;
          endcase
        end
        OPC_BRANCH: begin
          r.format = FMT_B;
          r.src1_reg = w[19:15];
          r.src2_reg = w[24:20];
          r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          case (f3)
            3'd0: r.operation = OP_BEQ;
            3'd1: r.operation = OP_BNE;
            3'd4: r.operation = OP_BLT;
            3'd5: r.operation = OP_BGE;
            3'd6: r.operation = OP_BLTU;
            3'd7: r.operation = OP_BGEU;
            default: ok = 1'b0;
          endcase
        end
        OPC_LUI, OPC_AUIPC: begin
          r.format = FMT_U;
          r.operation = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
          r.dest_reg = w[11:7];
          r.immediate = w & UPPER_MASK;
        end
        OPC_JAL: begin
          r.format = FMT_J;
          r.operation = OP_JAL;
          r.dest_reg = w[11:7];
          r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        r = '0;
        r.illegal = 1'b1;
      end
      return r;
    endfunction

    function string show(dec_result_t r);
      return $sformatf("ill=%0b fmt=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%08h",
                       r.illegal, r.format, r.operation, r.dest_reg, r.src1_reg,
                       r.src2_reg, r.immediate);
    endfunction

    function void note_input(logic [31:0] w);
      dec_result_t r;
      r = decode_word(w);
      if (r.illegal) illegal_seen++;
      else op_seen[r.operation] = 1'b1;
      pending_decodes.push_back(r);
    endfunction

    function void check_result(dec_result_t act);
      dec_result_t exp;
      bit          bad;
      if (pending_decodes.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected item: %s", show(act));
        return;
      end
      exp = pending_decodes.pop_front();
      checked++;
      bad = (act.illegal !== exp.illegal) || (act.format !== exp.format) ||
            (act.operation !== exp.operation) || (act.dest_reg !== exp.dest_reg) ||
            (act.src1_reg !== exp.src1_reg) || (act.src2_reg !== exp.src2_reg) ||
            (act.immediate !== exp.immediate);
      if (bad) begin
        errors++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch on item %0d\n  exp %s\n  got %s", checked, show(exp), show(act));
      end
    endfunction

    function int ops_covered();
      int n;
      n = 0;
      foreach (op_seen[i]) if (op_seen[i]) n++;
      return n;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] in_instruction = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_illegal;
  logic [2:0]  out_format;
  logic [5:0]  out_operation;
  logic [4:0]  out_dest_reg;
  logic [4:0]  out_src1_reg;
  logic [4:0]  out_src2_reg;
  logic signed [31:0] out_immediate;

  decode_board board = new;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          cycle_count = 0;

  rv32i_instruction_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_instruction (in_instruction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_illegal    (out_illegal),
    .out_format     (out_format),
    .out_operation  (out_operation),
    .out_dest_reg   (out_dest_reg),
    .out_src1_reg   (out_src1_reg),
    .out_src2_reg   (out_src2_reg),
    .out_immediate  (out_immediate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    dec_result_t act;
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_instruction);
      if (out_valid && out_ready) begin
        act.illegal   = out_illegal;
        act.format    = out_format;
        act.operation = out_operation;
        act.dest_reg  = out_dest_reg;
        act.src1_reg  = out_src1_reg;
        act.src2_reg  = out_src2_reg;
        act.immediate = out_immediate;
        board.check_result(act);
      end
    end
  end

  // receiver: random back-pressure, or a long hold on request
  initial begin
    int hold_count;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_instruction <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          sel;
    w = $urandom;
    // mostly well-formed encodings, some raw noise
    if ($urandom_range(99) < 10) return w;
    sel = $urandom_range(10);
    case (sel)
      0: w[6:0] = OPC_OP;
      1: w[6:0] = OPC_LOAD;
      2: w[6:0] = OPC_OP_IMM;
      3: w[6:0] = OPC_JALR;
      4: w[6:0] = OPC_SYSTEM;
      5: w[6:0] = OPC_FENCE;
      6: w[6:0] = OPC_STORE;
      7: w[6:0] = OPC_BRANCH;
      8: w[6:0] = OPC_LUI;
      9: w[6:0] = OPC_AUIPC;
      default: w[6:0] = OPC_JAL;
    endcase
    if (w[6:0] == OPC_OP || w[6:0] == OPC_OP_IMM) begin
      sel = $urandom_range(9);
      if (sel < 4) w[31:25] = F7_BASE;
      else if (sel < 8) w[31:25] = F7_ALT;
    end
    if (w[6:0] == OPC_SYSTEM && $urandom_range(3) != 0) begin
      w[14:12] = 3'd0;
      sel = $urandom_range(2);
      if (sel == 0) w[31:20] = F12_ECALL;
      else if (sel == 1) w[31:20] = F12_EBREAK;
    end
    return w;
  endfunction

  initial begin
    logic [31:0] directed[$];
    int          phase;
    int          n;

    directed = '{
      32'h0000_0000, 32'hFFFF_FFFF,                 // unknown opcodes
      32'h01FF_8FB3, 32'h4000_00B3, 32'h0200_0033,  // add all-ones regs, sub, bad funct7
      32'hFE00_1033, 32'h4000_5033,                 // sll ignores funct7, sra
      32'h0000_2063, 32'hFFFF_FFE3, 32'h7E00_0FE3,  // bad branch, branch imm -2 and max
      32'h0000_3003, 32'hFFF0_A083,                 // bad load, lw imm -1
      32'h8000_2023, 32'h0000_3023,                 // sw imm min, bad store
      32'hFFF0_1013, 32'h41F0_5013, 32'h0200_5013,  // slli odd funct7, srai, bad srli
      32'h8000_0013, 32'hFFFF_FFE7,                 // addi imm min, jalr all ones
      32'h0000_0073, 32'h0010_0073, 32'h000F_8FF3,  // ecall, ebreak, ecall with regs
      32'h0000_1073, 32'h0020_0073,                 // system bad funct3, bad funct12
      32'hFFFF_FF8F, 32'hFFFF_FFB7, 32'hFFFF_F017,  // fence, lui, auipc
      32'hFFFF_FFEF, 32'h7FFF_F06F                  // jal imm -2 and max
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 48;
    foreach (directed[i]) send_item(directed[i]);

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 48;
        recv_idle_pct = 34;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold while the sender keeps offering items
        if (phase == 2 && n == 40) hold_req = 1'b1;
        send_item(random_word());
      end
    end
    in_valid <= 1'b0;

    while (board.pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d decoded items, %0d illegal words, %0d of 40 operations",
             board.checked, board.illegal_seen, board.ops_covered());
    $display("phases: sender/receiver throttled both ways, then full rate with a long stall");
    if (board.errors == 0 && board.pending_decodes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors", board.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/idec_pkg.sv
rtl/idec_decode.sv
rtl/rv32i_instruction_decoder.sv
sim/tb_rv32i_instruction_decoder.sv
